[src/tfd_pkg.sv]
// Shared types and constants for the tablet frame decoder.
package tfd_pkg;

  // Frame format register codes
  typedef enum logic [1:0] {
    FMT_OFF  = 2'd0,
    FMT_FIVE = 2'd1,
    FMT_SIX  = 2'd2,
    FMT_RSVD = 2'd3
  } fmt_t;

  localparam int unsigned FRAME_MAX     = 6;
  localparam logic [2:0]  FIVE_LEN      = 3'd5;
  localparam logic [2:0]  SIX_LEN       = 3'd6;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam logic [5:0]  BTN_MIN       = 6'd30;
  localparam logic [5:0]  BTN_BASE      = 6'd32;
  localparam logic [13:0] PROX_X_MIN    = 14'd256;

  typedef logic [6:0] data7_t;

  // One completed frame, handed from the framer to the decoder
  typedef struct packed {
    logic                  six;
    data7_t [FRAME_MAX-1:0] bytes;
  } frame_t;

endpackage

[src/tfd_front.sv]
// Byte framer: accepts serial bytes and assembles complete frames.
module tfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_frame_format,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output logic              fq_push,
  output tfd_pkg::frame_t   fq_frame
);
  import tfd_pkg::*;

  fmt_t       fmt_r;
  logic [2:0] fill_r, fill_nxt;
  data7_t     frame_bytes_r [FRAME_MAX];
  logic [2:0] len;
  logic       active;
  logic       restart;
  logic [2:0] idx;
  logic [2:0] idx_inc;

  // Frame length per format
  always_comb begin
    len    = 3'd0;
    active = 1'b0;
    unique case (fmt_r)
      FMT_FIVE: begin
        len    = FIVE_LEN;
        active = 1'b1;
      end
      FMT_SIX: begin
        len    = SIX_LEN;
        active = 1'b1;
      end
      FMT_OFF, FMT_RSVD: begin
        len    = 3'd0;
        active = 1'b0;
      end
      default: begin
        len    = 3'd0;
        active = 1'b0;
      end
    endcase
  end

  // Slot for this byte: start byte or stale fill restarts the frame
  assign restart = rx_byte[7] || (fill_r >= len);
  assign idx     = restart ? 3'd0 : fill_r;
  assign idx_inc = idx + 3'd1;
  assign fill_nxt = idx_inc;

  // Frame contents including the byte arriving now
  always_comb begin
    fq_frame.six = (fmt_r == FMT_SIX);
    for (int i = 0; i < FRAME_MAX; i++) begin
      fq_frame.bytes[i] = (idx == 3'(i)) ? rx_byte[6:0] : frame_bytes_r[i];
    end
  end

  assign fq_push = accept && active && (idx_inc == len);

  // Format and fill registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= FMT_OFF;
      fill_r <= 3'd0;
    end else if (cfg_we) begin
      fmt_r  <= fmt_t'(cfg_frame_format);
      fill_r <= 3'd0;
    end else if (accept && active) begin
      fill_r <= fill_nxt;
    end
  end

  // Byte storage
  always_ff @(posedge clk) begin
    if (accept && active) begin
      frame_bytes_r[idx] <= rx_byte[6:0];
    end
  end

endmodule

[src/tfd_queue.sv]
// Short frame queue between the framer and the decoder.
module tfd_queue #(
  parameter int unsigned DEPTH = tfd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  tfd_pkg::frame_t wr_frame,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output tfd_pkg::frame_t rd_frame
);
  import tfd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  frame_t          entry_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_wr, do_rd;

  assign full     = (cnt_r == CntW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_frame = entry_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      if (do_wr && !do_rd)      cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) entry_r[wr_ptr_r] <= wr_frame;
  end

endmodule

[src/tfd_back.sv]
// Frame decoder: turns queued frames into results held in an output register.
module tfd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            fq_valid,
  input  tfd_pkg::frame_t fq_frame,
  output logic            fq_pop,
  output logic            out_valid,
  input  logic            out_take,
  output logic [15:0]     x_position,
  output logic [15:0]     y_position,
  output logic [15:0]     status_word,
  output logic [15:0]     sample_count
);
  import tfd_pkg::*;

  logic        out_valid_r;
  logic [15:0] x_r, y_r, st_r;
  logic [15:0] count_r, count_nxt;
  logic [15:0] x_dec, y_dec, st_dec;
  logic [13:0] xy5_x, xy5_y;
  logic [5:0]  v;
  logic [3:0]  sh;
  data7_t      b0, b1, b2, b3, b4, b5;

  assign b0 = fq_frame.bytes[0];
  assign b1 = fq_frame.bytes[1];
  assign b2 = fq_frame.bytes[2];
  assign b3 = fq_frame.bytes[3];
  assign b4 = fq_frame.bytes[4];
  assign b5 = fq_frame.bytes[5];

  // Decode of both frame formats
  always_comb begin
    xy5_x = {b1, b2};
    xy5_y = {b3, b4};
    v     = b0[5:0];
    sh    = (v <= BTN_BASE) ? 4'd0 : 4'((v - BTN_BASE) >> 1);
    if (fq_frame.six) begin
      st_dec = {11'd0, b0[6:2]};
      x_dec  = {b0[1:0], b1, b2};
      y_dec  = {b3[1:0], b4, b5};
    end else begin
      st_dec = {b0[6], 15'd0};
      if (v > BTN_MIN) st_dec = st_dec | (16'd1 << sh);
      // near the left edge bit 15 drops, whether proximity or button
      if (xy5_x < PROX_X_MIN) st_dec[15] = 1'b0;
      x_dec = {2'd0, xy5_x};
      y_dec = {2'd0, xy5_y};
    end
  end

  // Take a frame when the output register is free or being emptied
  assign fq_pop    = fq_valid && (!out_valid_r || out_take);
  assign count_nxt = count_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= 16'd0;
    end else begin
      if (cfg_we) count_r <= 16'd0;
      else if (fq_pop) count_r <= count_nxt;
      if (fq_pop) out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fq_pop) begin
      x_r  <= x_dec;
      y_r  <= y_dec;
      st_r <= st_dec;
    end
  end

  assign out_valid    = out_valid_r;
  assign x_position   = x_r;
  assign y_position   = y_r;
  assign status_word  = st_r;
  assign sample_count = count_r;

endmodule

[src/tablet_frame_decoder_top.sv]
// Tablet frame decoder: framer, frame queue and decoder.
//
// Usage: serial bytes enter on in_rx_byte, taken when push is high and full
// is low. The framer stores the low seven bits; bit 7 set, or a byte after a
// complete frame, starts a new frame. cfg_frame_format selects off (0, 3),
// five-byte (1) or six-byte (2) frames; a write to it also clears the byte
// fill and the sample count, and is made while the block is idle.
// Each completed frame gives one result: x, y, status and a wrapping 16-bit
// sample count, shown while empty is low and taken when pop is high.
// A frame's last byte enters the frame queue at the edge that takes it; the
// decoder then moves it into the output register once that is free or being
// taken. The framer takes one byte per cycle while full is low; the decoder
// takes one frame a cycle while the output register is free or being taken.
// When the receiver stalls, completed frames fill the frame queue (QUEUE_DEPTH
// entries) and full rises once it holds QUEUE_DEPTH frames.
// Reset (rst_n low, synchronous) empties the queue and output register,
// selects format off and clears the fill and sample count.
module tablet_frame_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = tfd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_frame_format,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_x_position,
  output logic [15:0] out_y_position,
  output logic [15:0] out_status_word,
  output logic [15:0] out_sample_count
);
  import tfd_pkg::*;

  logic   in_accept;
  logic   fq_push, fq_full, fq_valid, fq_pop;
  frame_t fq_wr_frame, fq_rd_frame;
  logic   out_valid, out_take;

  assign full      = fq_full;
  assign in_accept = push && !fq_full;
  assign out_take  = pop && out_valid;
  assign empty     = !out_valid;

  // Framer
  tfd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_frame_format (cfg_frame_format),
    .accept           (in_accept),
    .rx_byte          (in_rx_byte),
    .fq_push          (fq_push),
    .fq_frame         (fq_wr_frame)
  );

  // Frame queue
  tfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fq_push),
    .wr_frame (fq_wr_frame),
    .full     (fq_full),
    .rd_en    (fq_pop),
    .rd_valid (fq_valid),
    .rd_frame (fq_rd_frame)
  );

  // Decoder
  tfd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .fq_valid     (fq_valid),
    .fq_frame     (fq_rd_frame),
    .fq_pop       (fq_pop),
    .out_valid    (out_valid),
    .out_take     (out_take),
    .x_position   (out_x_position),
    .y_position   (out_y_position),
    .status_word  (out_status_word),
    .sample_count (out_sample_count)
  );

`ifndef SYNTH
  // Framer never completes a frame while the queue is full
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(fq_push && fq_full))
    else $error("frame completed while queue full");

  // Decoder only takes frames the queue holds
  a_pop_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
    fq_pop |-> fq_valid)
    else $error("decoder pop from empty queue");

  // A decoded frame is on the result ports the next cycle
  a_pop_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    fq_pop |=> !empty)
    else $error("decoded frame not presented");
`endif

endmodule

[sim/tfd_frame_checker.sv]
// Frame checker: predicts decoded tablet samples from accepted bytes and compares results.
`timescale 1ns / 100ps

module tfd_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_frame_format,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_rx_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [15:0] out_x_position,
  input  logic [15:0] out_y_position,
  input  logic [15:0] out_status_word,
  input  logic [15:0] out_sample_count,
  output int          frames_pending,
  output int          fail_count
);
  import tfd_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] status;
    logic [15:0] count;
  } tablet_sample_t;

  // Shadow copy of the framer state
  fmt_t        frame_fmt;
  data7_t      frame_bytes [FRAME_MAX];
  logic [2:0]  fill_count;
  logic [15:0] frames_seen;

  tablet_sample_t expected_samples [$];
  int             mismatches = 0;

  assign fail_count = mismatches;

  // Five-byte frame: button code in byte 0, 14-bit x and y
  function automatic tablet_sample_t decode_five();
    tablet_sample_t s;
    logic [5:0]     code;
    logic [13:0]    xp;
    int             btn;
    code     = frame_bytes[0][5:0];
    s.status = {frame_bytes[0][6], 15'd0};
    if (code > BTN_MIN) begin
      // codes 31 and 32 both land on bit 0
      btn = (code <= BTN_BASE) ? 0 : int'(code - BTN_BASE) / 2;
      s.status[btn] = 1'b1;
    end
    xp = {frame_bytes[1], frame_bytes[2]};
    // out of proximity near the left edge
    if (xp < PROX_X_MIN) s.status[15] = 1'b0;
    s.x     = {2'b00, xp};
    s.y     = {2'b00, frame_bytes[3], frame_bytes[4]};
    s.count = '0;
    return s;
  endfunction

  // Six-byte frame: top bits of x and y ride in bytes 0 and 3
  function automatic tablet_sample_t decode_six();
    tablet_sample_t s;
    s.status = {11'd0, frame_bytes[0][6:2]};
    s.x      = {frame_bytes[0][1:0], frame_bytes[1], frame_bytes[2]};
    s.y      = {frame_bytes[3][1:0], frame_bytes[4], frame_bytes[5]};
    s.count  = '0;
    return s;
  endfunction

  function automatic void frame_byte(input logic [7:0] b);
    logic [2:0]     len;
    tablet_sample_t s;
    case (frame_fmt)
      FMT_FIVE: len = FIVE_LEN;
      FMT_SIX:  len = SIX_LEN;
      default:  return;
    endcase
    // start bit or a byte after a full frame restarts the frame
    if (b[7] || fill_count >= len) fill_count = '0;
    frame_bytes[fill_count] = b[6:0];
    fill_count = fill_count + 3'd1;
    if (fill_count == len) begin
      s = (len == FIVE_LEN) ? decode_five() : decode_six();
      frames_seen = frames_seen + 16'd1;
      s.count     = frames_seen;
      expected_samples.push_back(s);
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  function automatic void check_sample();
    tablet_sample_t s;
    if (expected_samples.size() == 0) begin
      $error("unexpected sample: x %h y %h status %h count %h", out_x_position,
             out_y_position, out_status_word, out_sample_count);
      mismatches++;
      return;
    end
    s = expected_samples.pop_front();
    check_field("x_position", s.x, out_x_position);
    check_field("y_position", s.y, out_y_position);
    check_field("status_word", s.status, out_status_word);
    check_field("sample_count", s.count, out_sample_count);
  endfunction

  // Watch both channels and the format register at every edge
  always @(posedge clk) begin
    if (!rst_n) begin
      frame_fmt   = FMT_OFF;
      fill_count  = '0;
      frames_seen = '0;
      for (int i = 0; i < FRAME_MAX; i++) frame_bytes[i] = '0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        frame_fmt   = fmt_t'(cfg_frame_format);
        fill_count  = '0;
        frames_seen = '0;
      end
      if (push && !full) frame_byte(in_rx_byte);
      if (pop && !empty) check_sample();
    end
    frames_pending <= expected_samples.size();
  end

endmodule

[sim/tablet_frame_decoder_top_tb.sv]
// Testbench top: clock, reset, byte stream and receiver stalls for the tablet frame decoder.
`timescale 1ns / 100ps

module tablet_frame_decoder_top_tb;
  import tfd_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int TARGET_BYTES = 1200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_frame_format = FMT_OFF;
  logic        push = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [15:0] out_x_position;
  logic [15:0] out_y_position;
  logic [15:0] out_status_word;
  logic [15:0] out_sample_count;

  int   frames_pending;
  int   fail_count;
  int   cycle_count = 0;
  int   decoded_bytes = 0;
  int   burst_left = 1;
  bit   steady = 1'b0;
  fmt_t cur_fmt = FMT_OFF;

  logic [7:0] dir_five [20] = '{
    8'hFF, 8'h7F, 8'h7F, 8'h7F, 8'h7F,
    8'hDF, 8'h01, 8'h7F, 8'h00, 8'h00,
    8'hA0, 8'h02, 8'h00, 8'h7F, 8'h7F,
    8'h1E, 8'h00, 8'h00, 8'h00, 8'h00
  };

  always #4 clk = ~clk;

  tablet_frame_decoder_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_frame_format (cfg_frame_format),
    .push             (push),
    .full             (full),
    .in_rx_byte       (in_rx_byte),
    .empty            (empty),
    .pop              (pop),
    .out_x_position   (out_x_position),
    .out_y_position   (out_y_position),
    .out_status_word  (out_status_word),
    .out_sample_count (out_sample_count)
  );

  tfd_frame_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_frame_format (cfg_frame_format),
    .push             (push),
    .full             (full),
    .in_rx_byte       (in_rx_byte),
    .empty            (empty),
    .pop              (pop),
    .out_x_position   (out_x_position),
    .out_y_position   (out_y_position),
    .out_status_word  (out_status_word),
    .out_sample_count (out_sample_count),
    .frames_pending   (frames_pending),
    .fail_count       (fail_count)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random pop patterns, every sixth segment a long hold-off
  initial begin
    int seg;
    int mode;
    seg = 0;
    forever begin
      seg++;
      if (seg % 6 == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(150, 250)) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        repeat ($urandom_range(20, 60)) begin
          case (mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 3) != 0);
            default: pop <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // One item on the byte channel; bursts end in a random gap unless steady
  task automatic send_byte(input logic [7:0] b);
    push       <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    if (cur_fmt == FMT_FIVE || cur_fmt == FMT_SIX) decoded_bytes++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = steady ? 100000 : $urandom_range(1, 30);
      if (!steady) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  // Drain all pending samples before touching the format register
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_format(input fmt_t f);
    wait_idle();
    cfg_we           <= 1'b1;
    cfg_frame_format <= f;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_fmt = f;
  endtask

  // Mostly clean frames, some truncated, noisy or start-less runs
  task automatic send_sequence(input int len);
    int         kind;
    logic [6:0] d;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      send_byte({1'b1, 7'($urandom)});
      for (int i = 1; i < len; i++) begin
        d = 7'($urandom);
        // small x high byte to hit the proximity cutoff
        if (i == 1 && $urandom_range(0, 3) == 0) d = 7'($urandom_range(0, 2));
        send_byte({1'b0, d});
      end
    end else if (kind == 7) begin
      send_byte({1'b1, 7'($urandom)});
      repeat ($urandom_range(0, len - 2)) send_byte({1'b0, 7'($urandom)});
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else begin
      repeat (len) send_byte({1'b0, 7'($urandom)});
    end
  endtask

  initial begin
    fmt_t f;
    int   sel;
    int   phase_end;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Format off after reset: bytes are dropped
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'hFF);

    // Five-byte frames: all ones, button code 31 with x just under the cutoff,
    // code 32 with x at the cutoff, then a frame with no start byte
    write_format(FMT_FIVE);
    foreach (dir_five[i]) send_byte(dir_five[i]);

    // Six-byte frame with every data bit set
    write_format(FMT_SIX);
    send_byte(8'hFF);
    repeat (5) send_byte(8'h7F);

    // Unused format code and off both ignore bytes
    write_format(FMT_RSVD);
    send_byte(8'h85);
    send_byte(8'h12);
    write_format(FMT_OFF);
    send_byte(8'h90);
    send_byte(8'h7F);

    // Random phases
    while (decoded_bytes < TARGET_BYTES) begin
      sel = $urandom_range(0, 9);
      f   = (sel == 0) ? FMT_OFF : (sel == 1) ? FMT_RSVD : (sel < 6) ? FMT_FIVE : FMT_SIX;
      write_format(f);
      steady     = ($urandom_range(0, 3) == 0);
      burst_left = steady ? 100000 : $urandom_range(1, 30);
      if (f == FMT_FIVE || f == FMT_SIX) begin
        phase_end = decoded_bytes + $urandom_range(60, 200);
        while (decoded_bytes < phase_end)
          send_sequence((f == FMT_FIVE) ? int'(FIVE_LEN) : int'(SIX_LEN));
      end else begin
        repeat ($urandom_range(2, 4)) send_sequence($urandom_range(5, 6));
      end
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && frames_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[tablet_frame_decoder_top.f]
src/tfd_pkg.sv
src/tfd_front.sv
src/tfd_queue.sv
src/tfd_back.sv
src/tablet_frame_decoder_top.sv
sim/tfd_frame_checker.sv
sim/tablet_frame_decoder_top_tb.sv
